[rtl/mailbox_address_table_core_macros.svh]
// ----------------------------------------------------------------------------
// Mailbox address table assertion macros
// Property shorthands for the mailbox address table core.
// ----------------------------------------------------------------------------
`ifndef MAILBOX_ADDRESS_TABLE_CORE_MACROS_SVH
`define MAILBOX_ADDRESS_TABLE_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MAT_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define MAT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

[rtl/mat_pkg.sv]
// ----------------------------------------------------------------------------
// Mailbox address table package
// Operation and status codes and the result structure of the sequencer.
// ----------------------------------------------------------------------------
package mat_pkg;

	localparam logic [1:0] OP_SEND      = 2'd0;
	localparam logic [1:0] OP_RECEIVE   = 2'd1;
	localparam logic [1:0] OP_RECV_CLOSE = 2'd2;
	localparam logic [1:0] OP_CLEAR     = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNKNOWN   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_SATURATED = 3'd4;

	localparam logic [15:0] PEND_MAX = 16'hFFFF;
	localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] slot_index;
		logic [15:0] delivered_count;
		logic [16:0] freed_entries;
		logic [16:0] address_count;
		logic [31:0] message_total;
	} result_t;

endpackage

[rtl/mat_store.sv]
// ----------------------------------------------------------------------------
// Mailbox address table entry store
// One synchronous memory of key, owner and pending count per entry, with a
// registered read port; the core clears it with a write pass after reset,
// in place of a flash-cleared valid bit per set.
// ----------------------------------------------------------------------------
module mat_store #(
	parameter int ADDR_BITS = 16,
	parameter int ENTRY_BITS = 304
) (
	input  logic                  clk,
	input  logic [ADDR_BITS-1:0]  rd_addr,
	output logic [ENTRY_BITS-1:0] rd_data,
	input  logic                  wr_en,
	input  logic [ADDR_BITS-1:0]  wr_addr,
	input  logic [ENTRY_BITS-1:0] wr_data
);

	logic [ENTRY_BITS-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/mailbox_address_table_core.sv]
// Mailbox address table. One beat goes in, one result beat comes out. Send,
// receive and receive-with-close read the ways of one set one per cycle from
// the entry memory, then write back at most one entry. Clear-task walks every
// entry of the table, reading one entry per cycle and freeing each entry that
// the task owns. A finished result waits in a holding register while the
// previous result beat is stalled, and no input beat is taken meanwhile.
// After reset a clearing pass writes every entry free, one per cycle, during
// which no input beat is taken.
// ----------------------------------------------------------------------------
// Mailbox address table core
// Sequencer that searches, updates and frees mailbox entries in the store.
// ----------------------------------------------------------------------------
module mailbox_address_table_core #(
	parameter int SET_BITS = 12,
	parameter int WAY_BITS = 4,
	parameter int OWNER_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [63:0] key_word0,
	input  logic [63:0] key_word1,
	input  logic [63:0] key_word2,
	input  logic [63:0] key_word3,
	input  logic [31:0] task_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] slot_index,
	output logic [15:0] delivered_count,
	output logic [16:0] freed_entries,
	output logic [16:0] address_count,
	output logic [31:0] message_total
);

	`include "mailbox_address_table_core_macros.svh"

	localparam int ADDR_BITS = SET_BITS + WAY_BITS;
	localparam int ENTRY_BITS = 256 + OWNER_BITS + 16;
	localparam int CNT_BITS = ADDR_BITS + 1;

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DEC   = 3'd3;
	localparam logic [2:0] S_CLEAR = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q;
	logic [CNT_BITS-1:0] idx_q;
	logic [CNT_BITS-1:0] rd_idx_q;
	logic rd_live_q;
	logic [1:0] op_q;
	logic [255:0] key_q;
	logic [OWNER_BITS-1:0] task_q;
	logic [SET_BITS-1:0] set_q;
	logic found_q, have_free_q;
	logic [WAY_BITS:0] hit_way_q, free_way_q;
	logic [OWNER_BITS-1:0] hit_owner_q;
	logic [15:0] hit_pend_q;
	logic [16:0] owned_q;
	logic [31:0] total_q;
	logic [16:0] freed_q;
	mat_pkg::result_t next_res_q;
	mat_pkg::result_t res_q;
	logic out_valid_q;

	logic [ADDR_BITS-1:0] rd_addr, wr_addr;
	logic [ENTRY_BITS-1:0] rd_data, wr_data;
	logic wr_en;

	logic [255:0] rd_key;
	logic [OWNER_BITS-1:0] rd_owner;
	logic [15:0] rd_pend;
	logic [ADDR_BITS-1:0] rd_entry;
	logic [ADDR_BITS-1:0] base;
	logic [OWNER_BITS-1:0] in_task;
	logic accept;

	assign rd_key = rd_data[ENTRY_BITS-1 -: 256];
	assign rd_owner = rd_data[16 +: OWNER_BITS];
	assign rd_pend = rd_data[15:0];
	assign rd_entry = rd_idx_q[ADDR_BITS-1:0];
	assign base = {set_q, {WAY_BITS{1'b0}}} >> 0;
	assign in_task = OWNER_BITS >= 32 ? OWNER_BITS'(task_id) : task_id[OWNER_BITS-1:0];

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;

	mat_store #(.ADDR_BITS(ADDR_BITS), .ENTRY_BITS(ENTRY_BITS)) u_store (
		.clk    (clk),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// Read address and write-back selection.
	always_comb begin
		logic [ADDR_BITS-1:0] e;
		logic [15:0] np;
		logic [OWNER_BITS-1:0] no;
		rd_addr = idx_q[ADDR_BITS-1:0];
		if (state_q == S_SCAN) begin
			rd_addr = base | ADDR_BITS'(idx_q[WAY_BITS:0]);
		end
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		e = '0;
		np = '0;
		no = '0;
		if (state_q == S_INIT) begin
			wr_en = 1'b1;
			wr_addr = idx_q[ADDR_BITS-1:0];
		end else if (state_q == S_CLEAR && rd_live_q && task_q != '0
				&& rd_owner == task_q) begin
			wr_en = 1'b1;
			wr_addr = rd_entry;
			wr_data = {rd_key, {OWNER_BITS{1'b0}}, 16'd0};
		end else if (state_q == S_DEC) begin
			if (op_q == mat_pkg::OP_SEND) begin
				if (found_q && hit_pend_q != mat_pkg::PEND_MAX) begin
					wr_en = 1'b1;
					e = base | ADDR_BITS'(hit_way_q[WAY_BITS-1:0]);
					wr_data = {key_q, hit_owner_q, hit_pend_q + 16'd1};
				end
			end else if (task_q != '0) begin
				if (found_q && hit_owner_q == task_q) begin
					wr_en = 1'b1;
					e = base | ADDR_BITS'(hit_way_q[WAY_BITS-1:0]);
					no = (op_q == mat_pkg::OP_RECV_CLOSE) ? '0 : task_q;
					wr_data = {key_q, no, np};
				end else if (!found_q && have_free_q) begin
					wr_en = 1'b1;
					e = base | ADDR_BITS'(free_way_q[WAY_BITS-1:0]);
					no = (op_q == mat_pkg::OP_RECV_CLOSE) ? '0 : task_q;
					wr_data = {key_q, no, np};
				end
			end
			wr_addr = e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			idx_q <= '0;
			rd_live_q <= 1'b0;
			owned_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			rd_live_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == CNT_BITS'(2**ADDR_BITS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q <= operation;
						key_q <= {key_word3, key_word2, key_word1, key_word0};
						task_q <= in_task;
						set_q <= key_word0[SET_BITS-1:0];
						found_q <= 1'b0;
						have_free_q <= 1'b0;
						hit_way_q <= '0;
						free_way_q <= '0;
						freed_q <= '0;
						idx_q <= '0;
						state_q <= (operation == mat_pkg::OP_CLEAR) ? S_CLEAR : S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_live_q) begin
						if (rd_owner != '0) begin
							if (!found_q && rd_key == key_q) begin
								found_q <= 1'b1;
								hit_way_q <= rd_idx_q[WAY_BITS:0] - 1'b1;
								hit_owner_q <= rd_owner;
								hit_pend_q <= rd_pend;
							end
						end else if (!have_free_q) begin
							have_free_q <= 1'b1;
							free_way_q <= rd_idx_q[WAY_BITS:0] - 1'b1;
						end
					end
					if (idx_q[WAY_BITS:0] == (WAY_BITS+1)'(2**WAY_BITS)) begin
						if (rd_live_q) state_q <= S_DEC;
					end else begin
						idx_q <= idx_q + 1'b1;
						rd_live_q <= 1'b1;
					end
					rd_idx_q <= idx_q + 1'b1;
				end
				S_DEC: begin
					next_res_q.status <= mat_pkg::ST_OK;
					next_res_q.slot_index <= '0;
					next_res_q.delivered_count <= '0;
					next_res_q.freed_entries <= '0;
					next_res_q.address_count <= owned_q;
					next_res_q.message_total <= total_q;
					if (op_q == mat_pkg::OP_SEND) begin
						if (!found_q) begin
							next_res_q.status <= have_free_q ? mat_pkg::ST_UNKNOWN :
								mat_pkg::ST_FULL;
						end else begin
							next_res_q.slot_index <=
								16'(base | ADDR_BITS'(hit_way_q[WAY_BITS-1:0]));
							if (hit_pend_q == mat_pkg::PEND_MAX) begin
								next_res_q.status <= mat_pkg::ST_SATURATED;
							end else begin
								next_res_q.message_total <= (total_q == mat_pkg::TOTAL_MAX) ?
									total_q : total_q + 32'd1;
								total_q <= (total_q == mat_pkg::TOTAL_MAX) ?
									total_q : total_q + 32'd1;
							end
						end
					end else if (task_q == '0) begin
						next_res_q.status <= mat_pkg::ST_UNKNOWN;
					end else if (found_q && hit_owner_q != task_q) begin
						next_res_q.status <= mat_pkg::ST_UNKNOWN;
					end else if (!found_q && !have_free_q) begin
						next_res_q.status <= mat_pkg::ST_FULL;
					end else begin
						logic [15:0] dl;
						logic [16:0] own;
						logic [31:0] tot;
						dl = found_q ? hit_pend_q : 16'd0;
						own = found_q ? owned_q : owned_q + 17'd1;
						if (op_q == mat_pkg::OP_RECV_CLOSE && own != '0) own = own - 17'd1;
						tot = (total_q > 32'(dl)) ? total_q - 32'(dl) : 32'd0;
						next_res_q.slot_index <= 16'(base | ADDR_BITS'(found_q ?
							hit_way_q[WAY_BITS-1:0] : free_way_q[WAY_BITS-1:0]));
						next_res_q.delivered_count <= dl;
						next_res_q.status <= (dl == 16'd0) ? mat_pkg::ST_EMPTY : mat_pkg::ST_OK;
						next_res_q.address_count <= own;
						next_res_q.message_total <= tot;
						owned_q <= own;
						total_q <= tot;
					end
					state_q <= S_OUT;
				end
				S_CLEAR: begin
					if (rd_live_q && task_q != '0 && rd_owner == task_q) begin
						freed_q <= freed_q + 17'd1;
						if (owned_q != '0) owned_q <= owned_q - 17'd1;
						total_q <= (total_q > 32'(rd_pend)) ? total_q - 32'(rd_pend) : 32'd0;
					end
					if (idx_q == CNT_BITS'(2**ADDR_BITS)) begin
						if (!rd_live_q) begin
							next_res_q.status <= mat_pkg::ST_OK;
							next_res_q.slot_index <= '0;
							next_res_q.delivered_count <= '0;
							next_res_q.freed_entries <= freed_q;
							next_res_q.address_count <= owned_q;
							next_res_q.message_total <= total_q;
							state_q <= S_OUT;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						rd_live_q <= 1'b1;
					end
					rd_idx_q <= idx_q;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						res_q <= next_res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign slot_index = res_q.slot_index;
	assign delivered_count = res_q.delivered_count;
	assign freed_entries = res_q.freed_entries;
	assign address_count = res_q.address_count;
	assign message_total = res_q.message_total;

	`MAT_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, in_stall)
	`MAT_ASSERT_NEXT(a_out_after_out, clk, arst_n, state_q == S_OUT && (!out_valid_q || !out_stall), out_valid_q)
	`MAT_ASSERT_IMP(a_owned_bound, clk, arst_n, 1'b1, owned_q <= 17'(2**ADDR_BITS))

endmodule
